// ----- src/imufd_pkg.sv -----
// Shared constants, types and codes of the IMU frame decoder.
package imufd_pkg;

  localparam int unsigned FramesPerReception = 4;
  localparam int unsigned FrameBytes         = 11;
  localparam int unsigned ReceptionBytes     = FramesPerReception * FrameBytes;
  localparam int unsigned PosW               = $clog2(ReceptionBytes + 1);
  localparam int unsigned OffW               = $clog2(FrameBytes);

  localparam int unsigned RawWords    = 4;
  localparam int unsigned HeldBytes   = 7;
  localparam int unsigned HeldIdxW    = $clog2(HeldBytes);
  localparam int unsigned ValueW      = 28;
  localparam int unsigned ValueWW     = 17;
  localparam int unsigned OutDataW    = 104;

  localparam logic [7:0] HeaderReset = 8'h55;

  // Byte offsets inside a frame.
  localparam logic [OffW-1:0] OffHeader   = OffW'(0);
  localparam logic [OffW-1:0] OffType     = OffW'(1);
  localparam logic [OffW-1:0] OffData0    = OffW'(2);
  localparam logic [OffW-1:0] OffDataLast = OffW'(9);
  localparam logic [OffW-1:0] OffLast     = OffW'(FrameBytes - 1);

  // Frame type codes.
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeGyro  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;
  localparam logic [7:0] TypeQuat  = 8'h59;

  // Q.16 scale factors: full scale / 32768 * 65536.
  localparam logic [12:0] ScaleAccel = 13'd32;
  localparam logic [12:0] ScaleGyro  = 13'd4000;
  localparam logic [12:0] ScaleAngle = 13'd360;
  localparam logic [12:0] ScaleQuat  = 13'd2;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_QUAT  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic [RawWords-1:0][15:0]  raw;
  } raw_frame_t;

endpackage

// ----- src/imufd_scaler.sv -----
// Constant scaling of the four raw words of a frame into Q.16 values.
module imufd_scaler (
  input  imufd_pkg::raw_frame_t             frame_i,
  output logic signed [imufd_pkg::ValueW-1:0]  value_x_o,
  output logic signed [imufd_pkg::ValueW-1:0]  value_y_o,
  output logic signed [imufd_pkg::ValueW-1:0]  value_z_o,
  output logic signed [imufd_pkg::ValueWW-1:0] value_w_o
);
  import imufd_pkg::*;

  logic        [12:0]       scale;
  logic signed [ValueW-1:0] scale_s;
  logic signed [ValueW-1:0] prod [RawWords];

  always_comb begin
    unique case (frame_i.kind)
      KIND_ACCEL: scale = ScaleAccel;
      KIND_GYRO:  scale = ScaleGyro;
      KIND_ANGLE: scale = ScaleAngle;
      KIND_QUAT:  scale = ScaleQuat;
      default:    scale = ScaleAccel;
    endcase
  end

  assign scale_s = $signed({{(ValueW-13){1'b0}}, scale});

  for (genvar i = 0; i < RawWords; i++) begin : g_mul
    logic signed [ValueW-1:0] raw_s;
    assign raw_s   = $signed({{(ValueW-16){frame_i.raw[i][15]}}, frame_i.raw[i]});
    assign prod[i] = raw_s * scale_s;
  end

  assign value_x_o = prod[0];
  assign value_y_o = prod[1];
  assign value_z_o = prod[2];
  // Fourth component exists only for quaternions.
  assign value_w_o = (frame_i.kind == KIND_QUAT) ? prod[3][ValueWW-1:0] : '0;

endmodule

// ----- src/imu_frame_decoder_unit.sv -----
// Top level of the IMU frame decoder: byte sequencing, frame capture and output register.
// A frame's result is captured in the frame register and then in the output register after its last data byte.
// Throughput: one byte per cycle; the byte counter, a frame register and the output
// register form a two-stage pipeline that stalls only when both stages are full.
// Reset: asynchronous, active low; header register returns to 0x55, the decoder
// waits for a reception start, and both pipeline stages are emptied.
module imu_frame_decoder_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,      // header_byte
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,     // [7:0] rx_byte
  input  logic          s_axis_tuser,     // [0] buffer_start
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,     // [27:0] x, [55:28] y, [83:56] z, [100:84] w
  output logic [1:0]    m_axis_tuser      // [1:0] kind
);
  import imufd_pkg::*;

  // Configuration
  logic [7:0] header_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
    end else if (cfg_we_i) begin
      header_q <= cfg_wdata_i;
    end
  end

  // Pipeline control
  logic       frame_valid_q;
  logic       out_valid_q;
  logic       out_ready;
  logic       in_xfer;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !frame_valid_q || out_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Byte sequencing: position in the reception and offset in the frame
  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [OffW-1:0] off_q, off_d, off_eff;
  logic            abandon_q, abandon_d, abandon_eff;
  logic [7:0]      type_q, type_d;
  logic [7:0]      held_q [HeldBytes];
  logic            held_we;
  logic [HeldIdxW-1:0] held_idx;
  logic [OffW-1:0] held_off;
  logic            in_reception;
  logic            frame_done;
  logic            type_known;
  kind_e           type_kind;
  raw_frame_t      frame_d, frame_q;

  // A start flag restarts the reception at position 0 and clears the abandon flag.
  assign pos_eff      = s_axis_tuser ? '0 : pos_q;
  assign off_eff      = s_axis_tuser ? '0 : off_q;
  assign abandon_eff  = s_axis_tuser ? 1'b0 : abandon_q;
  assign in_reception = (pos_eff < PosW'(ReceptionBytes));
  assign held_off     = off_eff - OffData0;
  assign held_idx     = held_off[HeldIdxW-1:0];

  always_comb begin
    unique case (type_q)
      TypeAccel: begin type_known = 1'b1; type_kind = KIND_ACCEL; end
      TypeGyro:  begin type_known = 1'b1; type_kind = KIND_GYRO;  end
      TypeAngle: begin type_known = 1'b1; type_kind = KIND_ANGLE; end
      TypeQuat:  begin type_known = 1'b1; type_kind = KIND_QUAT;  end
      default:   begin type_known = 1'b0; type_kind = KIND_ACCEL; end
    endcase
  end

  always_comb begin
    pos_d      = pos_q;
    off_d      = off_q;
    abandon_d  = abandon_eff;
    type_d     = type_q;
    held_we    = 1'b0;
    frame_done = 1'b0;
    if (in_reception) begin
      pos_d = pos_eff + PosW'(1);
      off_d = (off_eff == OffLast) ? '0 : off_eff + OffW'(1);
      if (!abandon_eff) begin
        if (off_eff == OffHeader) begin
          // Wrong header: drop the rest of this reception.
          abandon_d = (s_axis_tdata != header_q);
        end else if (off_eff == OffType) begin
          type_d = s_axis_tdata;
        end else if (off_eff == OffDataLast) begin
          frame_done = type_known;
        end else if (off_eff < OffDataLast) begin
          held_we = 1'b1;
        end
      end
    end else if (s_axis_tuser) begin
      abandon_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= PosW'(ReceptionBytes);
      off_q     <= '0;
      abandon_q <= 1'b0;
      type_q    <= '0;
    end else if (in_xfer) begin
      pos_q     <= pos_d;
      off_q     <= off_d;
      abandon_q <= abandon_d;
      type_q    <= type_d;
    end
  end

  // Data bytes 0..6 of the frame; byte 7 is taken straight from the bus.
  always_ff @(posedge clk_i) begin
    if (in_xfer && held_we) begin
      held_q[held_idx] <= s_axis_tdata;
    end
  end

  always_comb begin
    frame_d.kind   = type_kind;
    frame_d.raw[0] = {held_q[1], held_q[0]};
    frame_d.raw[1] = {held_q[3], held_q[2]};
    frame_d.raw[2] = {held_q[5], held_q[4]};
    frame_d.raw[3] = {s_axis_tdata, held_q[6]};
  end

  // Frame register: holds a completed frame until the output stage takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      frame_valid_q <= in_xfer && frame_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && frame_done) begin
      frame_q <= frame_d;
    end
  end

  // Scaling into Q.16
  logic signed [ValueW-1:0]  val_x, val_y, val_z;
  logic signed [ValueWW-1:0] val_w;

  imufd_scaler u_scaler (
    .frame_i   (frame_q),
    .value_x_o (val_x),
    .value_y_o (val_y),
    .value_z_o (val_z),
    .value_w_o (val_w)
  );

  // Output register
  logic [OutDataW-1:0] out_data_q;
  kind_e               out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= frame_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && frame_valid_q) begin
      out_data_q <= {3'b000, val_w, val_z, val_y, val_x};
      out_kind_q <= frame_q.kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

`ifndef SYNTHESIS
  // Position never runs past the end of a reception.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(ReceptionBytes))
    else $error("byte position beyond reception");

  // Frame offset stays inside a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= OffLast)
    else $error("frame offset out of range");

  // A stalled frame stays in the frame register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_q && !out_ready |=> frame_valid_q)
    else $error("frame lost under output stall");

  // Only quaternions carry a fourth component.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q != KIND_QUAT |-> out_data_q[100:84] == '0)
    else $error("fourth component set for non-quaternion");
`endif

endmodule
